// ----- src/status_record_field_parser_defines.svh -----
// assertion macros for the status record field parser checker
`ifndef STATUS_RECORD_FIELD_PARSER_DEFINES_SVH
`define STATUS_RECORD_FIELD_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SRFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srfp check failed");

// next-cycle implication, sampled on clk, off during reset
`define SRFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srfp check failed");

`endif

// ----- src/srfp_pkg.sv -----
// shared types and character constants of the status record field parser
`default_nettype none
package srfp_pkg;

	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int OUT_BITS           = 32;
	localparam int SLOT_COUNT         = 7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_L     = 8'h4c;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;

	// slot order matches the result fields
	localparam logic [7:0] SLOT_LETTERS [SLOT_COUNT] = '{CH_S, CH_L, CH_T, CH_H, CH_A, CH_P, CH_F};

	typedef struct packed {
		logic [7:0] symbol;
		logic       last_symbol;
	} srfp_in_t;

	typedef struct packed {
		logic                       record_valid;
		logic                       malformed;
		logic signed [OUT_BITS-1:0] pilot_state;
		logic signed [OUT_BITS-1:0] line_voltage;
		logic signed [OUT_BITS-1:0] temperature;
		logic signed [OUT_BITS-1:0] h_value;
		logic signed [OUT_BITS-1:0] current_amps;
		logic signed [OUT_BITS-1:0] power_value;
		logic signed [OUT_BITS-1:0] fallback_limit;
	} srfp_out_t;

	typedef struct packed {
		logic       is_digit;
		logic [3:0] value;
	} srfp_digit_t;

endpackage
`default_nettype wire

// ----- src/srfp_stream_if.sv -----
// valid/ready stream channel with a typed payload
`default_nettype none
interface srfp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/srfp_char_decode.sv -----
// classifies one character as a digit of the current radix
`default_nettype none
module srfp_char_decode
	import srfp_pkg::*;
(
	input  wire logic [7:0]  symbol,
	input  wire logic        hex_radix,
	output srfp_digit_t      digit
);
	logic       found;
	logic [7:0] offs;

	always_comb begin
		found = 1'b1;
		if (symbol >= CH_0 && symbol <= CH_9) begin
			offs = symbol - CH_0;
		end else if (symbol >= CH_UC_A && symbol <= CH_UC_F) begin
			offs = symbol - CH_UC_A + 8'd10;
		end else if (symbol >= CH_LC_A && symbol <= CH_LC_F) begin
			offs = symbol - CH_LC_A + 8'd10;
		end else begin
			offs  = 8'd0;
			found = 1'b0;
		end
		digit.value    = offs[3:0];
		// letters A-F and a-f only count in hex
		digit.is_digit = found && (hex_radix || offs < 8'd10);
	end
endmodule
`default_nettype wire

// ----- src/status_record_field_parser.sv -----
// top level of the status record field parser
// Takes one ASCII character per beat on in_ch, last_symbol marking the final
// character of a status payload, and gives one result beat on out_ch for each
// payload, built from its S (hex), L, T, H, A, P and F fields. The block takes
// one character every cycle while no last character is stalled: a beat is
// captured in an input register, and from there the parser state and the seven
// stored values are updated by one decode and one shift-add by the radix. The
// result of a payload is loaded into the output register at the edge where its
// last character leaves the input register. While the result waits, characters
// of the next payload keep flowing, and only a second last character stalls
// until the result is taken.
// Values accumulate over VALUE_BITS bits and are given as their low 32 bits.
// All parser state clears after each result, so payloads are independent.
`default_nettype none
module status_record_field_parser
	import srfp_pkg::*;
#(
	parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
	input wire logic     clk,
	input wire logic     arst_n,
	srfp_stream_if.sink   in_ch,
	srfp_stream_if.source out_ch
);
	typedef enum logic [2:0] {
		PH_LETTER,
		PH_SIGN,
		PH_AFTER_SIGN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	// input register
	srfp_in_t in_s1;
	logic     valid_s1;

	// parser state
	phase_t                phase_q;
	logic [7:0]            letter_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	logic                  seen_q;
	logic                  bad_q;
	logic [VALUE_BITS-1:0] vals_q [SLOT_COUNT];

	// result register
	srfp_out_t out_q;
	logic      out_valid_q;

	logic out_free;
	logic advance_s1;

	assign out_free   = !out_valid_q || out_ch.ready;
	// a last character needs the result register free, others always move
	assign advance_s1 = valid_s1 && (!in_s1.last_symbol || out_free);
	assign in_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			in_s1 <= in_ch.payload;
		end
	end

	// digit decode in the radix of the open field
	srfp_digit_t digit;
	logic        hex_radix;

	assign hex_radix = (letter_q == CH_S);

	srfp_char_decode u_decode (
		.symbol    (in_s1.symbol),
		.hex_radix (hex_radix),
		.digit     (digit)
	);

	// multiply-add by the radix as shifts
	logic [VALUE_BITS-1:0] acc_x10;
	logic [VALUE_BITS-1:0] acc_x16;
	logic [VALUE_BITS-1:0] acc_mac;

	assign acc_x10 = (acc_q << 3) + (acc_q << 1);
	assign acc_x16 = acc_q << 4;
	assign acc_mac = (hex_radix ? acc_x16 : acc_x10) + VALUE_BITS'(digit.value);

	// next state
	phase_t                n_phase;
	logic [7:0]            n_letter;
	logic [VALUE_BITS-1:0] n_acc;
	logic                  n_neg;
	logic                  n_seen;
	logic                  n_bad;
	logic                  commit;
	logic [7:0]            commit_letter;
	logic [VALUE_BITS-1:0] commit_acc;
	logic                  commit_neg;
	logic [VALUE_BITS-1:0] commit_val;
	logic [VALUE_BITS-1:0] n_vals [SLOT_COUNT];

	always_comb begin
		n_phase       = phase_q;
		n_letter      = letter_q;
		n_acc         = acc_q;
		n_neg         = neg_q;
		n_bad         = bad_q;
		commit        = 1'b0;
		commit_letter = letter_q;
		commit_acc    = acc_q;
		commit_neg    = neg_q;

		case (phase_q)
			PH_LETTER: begin
				if (in_s1.symbol == CH_NUL) begin
					n_phase = PH_DONE;
				end else begin
					n_letter = in_s1.symbol;
					n_acc    = '0;
					n_neg    = 1'b0;
					n_phase  = PH_SIGN;
				end
			end
			PH_SIGN, PH_AFTER_SIGN: begin
				if (phase_q == PH_SIGN && in_s1.symbol == CH_MINUS) begin
					n_neg   = 1'b1;
					n_phase = PH_AFTER_SIGN;
				end else if (digit.is_digit) begin
					n_acc   = acc_mac;
					n_phase = PH_DIGITS;
				end else begin
					// letter with no digits
					n_bad   = 1'b1;
					n_phase = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (digit.is_digit) begin
					n_acc = acc_mac;
				end else begin
					commit = 1'b1;
					if (in_s1.symbol == CH_COMMA) begin
						n_phase = PH_LETTER;
					end else if (in_s1.symbol == CH_NUL) begin
						n_phase = PH_DONE;
					end else begin
						// the ending character opens the next field
						n_letter = in_s1.symbol;
						n_acc    = '0;
						n_neg    = 1'b0;
						n_phase  = PH_SIGN;
					end
				end
			end
			default: begin
			end
		endcase

		// end of payload closes whatever field is open
		if (in_s1.last_symbol) begin
			if (n_phase == PH_SIGN || n_phase == PH_AFTER_SIGN) begin
				n_bad = 1'b1;
			end else if (n_phase == PH_DIGITS) begin
				commit        = 1'b1;
				commit_letter = n_letter;
				commit_acc    = n_acc;
				commit_neg    = n_neg;
			end
		end

		commit_val = commit_neg ? VALUE_BITS'(~commit_acc + 1'b1) : commit_acc;
		n_seen     = seen_q || commit;

		for (int i = 0; i < SLOT_COUNT; i++) begin
			n_vals[i] = (commit && commit_letter == SLOT_LETTERS[i]) ? commit_val : vals_q[i];
		end
	end

	// low 32 bits of a value, zero-extended when narrower
	function automatic logic [OUT_BITS-1:0] to_out(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS+OUT_BITS-1:0] wide;
		wide   = {{OUT_BITS{1'b0}}, v};
		to_out = wide[OUT_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LETTER;
			letter_q    <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				vals_q[i] <= '0;
			end
		end else begin
			// a new record wins over the beat being taken
			if (advance_s1 && in_s1.last_symbol) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance_s1) begin
				if (in_s1.last_symbol) begin
					// emit the record and start the next payload clean
					out_q.record_valid   <= n_seen && !n_bad;
					out_q.malformed      <= n_bad;
					out_q.pilot_state    <= to_out(n_vals[0]);
					out_q.line_voltage   <= to_out(n_vals[1]);
					out_q.temperature    <= to_out(n_vals[2]);
					out_q.h_value        <= to_out(n_vals[3]);
					out_q.current_amps   <= to_out(n_vals[4]);
					out_q.power_value    <= to_out(n_vals[5]);
					out_q.fallback_limit <= to_out(n_vals[6]);
					phase_q  <= PH_LETTER;
					letter_q <= '0;
					acc_q    <= '0;
					neg_q    <= 1'b0;
					seen_q   <= 1'b0;
					bad_q    <= 1'b0;
					for (int i = 0; i < SLOT_COUNT; i++) begin
						vals_q[i] <= '0;
					end
				end else begin
					phase_q  <= n_phase;
					letter_q <= n_letter;
					acc_q    <= n_acc;
					neg_q    <= n_neg;
					seen_q   <= n_seen;
					bad_q    <= n_bad;
					for (int i = 0; i < SLOT_COUNT; i++) begin
						vals_q[i] <= n_vals[i];
					end
				end
			end
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_q;
endmodule
`default_nettype wire

// ----- src/srfp_checker.sv -----
// port-level assertions for the status record field parser, with bind
`default_nettype none
`include "status_record_field_parser_defines.svh"
module srfp_checker
	import srfp_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire srfp_out_t out_payload
);
	// an empty result register never holds back input
	`SRFP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
	// a record cannot be both good and malformed
	`SRFP_ASSERT_NOW(a_valid_excl_bad, out_valid, !(out_payload.record_valid && out_payload.malformed))
	// a stalled result beat stays up
	`SRFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// a stalled result beat keeps its payload
	`SRFP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))
endmodule

bind status_record_field_parser srfp_checker u_srfp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_payload (out_ch.payload)
);
`default_nettype wire
